@@ hw/rtl/mm_pkg.sv @@
// Shared types and constants for the fixed-point matrix multiply block.
package mm_pkg;

  // Default sizes
  localparam int unsigned MAX_DIM_DEF   = 16;
  localparam int unsigned ELEM_BITS_DEF = 16;

  // Fixed field widths on the ports
  localparam int unsigned FIELD_IDX_W = 4;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned OP_W        = 2;

  // Input opcodes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } mm_op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } mm_reg_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_WAIT,
    ST_EMIT
  } mm_state_e;

  // Control that travels down the cell chain with each A element
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mm_ctl_t;

endpackage

@@ hw/rtl/mm_mac_cell.sv @@
// One multiply-accumulate cell: holds a column of B and one result accumulator.
module mm_mac_cell import mm_pkg::*; #(
  parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
  parameter int unsigned ELEM_BITS = ELEM_BITS_DEF,
  parameter int unsigned CELL_IDX  = 0,
  localparam int unsigned IDX_W    = $clog2(MAX_DIM),
  localparam int unsigned ACC_W    = 2 * ELEM_BITS + $clog2(MAX_DIM) + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // element stream from the previous cell
  input  mm_ctl_t                     ctl_i,
  input  logic signed [ELEM_BITS-1:0] a_i,
  input  logic        [IDX_W-1:0]     k_i,
  // B element write bus, shared by all cells
  input  logic                        b_we_i,
  input  logic        [IDX_W-1:0]     b_row_i,
  input  logic        [IDX_W-1:0]     b_col_i,
  input  logic signed [ELEM_BITS-1:0] b_val_i,
  // element stream to the next cell
  output mm_ctl_t                     ctl_o,
  output logic signed [ELEM_BITS-1:0] a_o,
  output logic        [IDX_W-1:0]     k_o,
  // running dot product of this column
  output logic signed [ACC_W-1:0]     acc_o
);

  logic signed [ELEM_BITS-1:0]   b_col_q [MAX_DIM];
  mm_ctl_t                       pass_ctl_q;
  logic signed [ELEM_BITS-1:0]   pass_a_q;
  logic        [IDX_W-1:0]       pass_k_q;
  logic signed [2*ELEM_BITS-1:0] prod_d, prod_q;
  mm_ctl_t                       prod_ctl_q;
  logic signed [ACC_W-1:0]       acc_d, acc_q;

  // Local copy of B column CELL_IDX
  always_ff @(posedge clk_i) begin
    if (b_we_i && (b_col_i == IDX_W'(CELL_IDX))) begin
      b_col_q[b_row_i] <= b_val_i;
    end
  end

  // Hand the element on to the neighbour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_ctl_q <= '0;
      prod_ctl_q <= '0;
    end else begin
      pass_ctl_q <= ctl_i;
      prod_ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_a_q <= a_i;
    pass_k_q <= k_i;
  end

  // Multiply stage
  assign prod_d = a_i * b_col_q[k_i];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Accumulate stage; the first term of a row restarts the sum
  always_comb begin
    acc_d = acc_q;
    if (prod_ctl_q.vld) begin
      if (prod_ctl_q.first) begin
        acc_d = ACC_W'(prod_q);
      end else begin
        acc_d = acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign ctl_o = pass_ctl_q;
  assign a_o   = pass_a_q;
  assign k_o   = pass_k_q;
  assign acc_o = acc_q;

endmodule

@@ hw/rtl/matrix_multiply.sv @@
// Matrix multiply top level: A store, sequencer, chain of MAC cells, result output.
// A compute request streams its A row down a chain of MAX_DIM cells, one element a
// cycle; once the row has left the last cell, results follow at one result per cycle
// while m_axis_tready does not hold the output, cols_b results in all. Reset clears
// control and sets all size registers to MAX_DIM; the element stores keep no reset
// value.
module matrix_multiply import mm_pkg::*; #(
  parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
  parameter int unsigned ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // requests in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // row[3:0], col[7:4], value[23:8]
  input  logic [OP_W-1:0]      s_axis_tuser,  // opcode[1:0]
  // results out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,  // out_row[3:0], out_col[7:4], sum[39:8]
  output logic                 m_axis_tlast   // last result of the row
);

  localparam int unsigned IDX_W   = $clog2(MAX_DIM);
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned ACC_W   = 2 * ELEM_BITS + $clog2(MAX_DIM) + 1;
  localparam int unsigned EXT_W   = (ACC_W > SUM_W + 1) ? ACC_W : SUM_W + 1;
  localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(signed'(32'h7FFF_FFFF));
  localparam logic signed [EXT_W-1:0] SAT_MIN = EXT_W'(signed'(32'h8000_0000));

  // Request fields
  logic [FIELD_IDX_W-1:0]      in_row, in_col;
  logic signed [VALUE_W-1:0]   in_value;
  logic signed [ELEM_BITS-1:0] in_elem;
  logic                        in_acc;
  logic                        idx_ok;

  assign in_row   = s_axis_tdata[3:0];
  assign in_col   = s_axis_tdata[7:4];
  assign in_value = s_axis_tdata[23:8];
  assign in_elem  = ELEM_BITS'(in_value);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign idx_ok   = ((FIELD_IDX_W + 1)'(in_row) < (FIELD_IDX_W + 1)'(MAX_DIM)) &&
                    ((FIELD_IDX_W + 1)'(in_col) < (FIELD_IDX_W + 1)'(MAX_DIM));

  // Size registers
  logic [DIM_W-1:0] rows_a_q, inner_q, cols_b_q;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (CFG_W'(v) > CFG_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= DIM_W'(MAX_DIM);
      inner_q  <= DIM_W'(MAX_DIM);
      cols_b_q <= DIM_W'(MAX_DIM);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROWS_A:    rows_a_q <= clamp_dim(cfg_data_i);
        REG_INNER_DIM: inner_q  <= clamp_dim(cfg_data_i);
        REG_COLS_B:    cols_b_q <= clamp_dim(cfg_data_i);
        default:       ;
      endcase
    end
  end

  // Sequencer
  mm_state_e          state_q, state_d;
  logic [IDX_W-1:0]   row_q, row_d;
  logic [IDX_W-1:0]   k_q, k_d;
  logic [IDX_W-1:0]   j_q, j_d;
  logic               a_we, b_we;
  logic [ADDR_W-1:0]  a_waddr, a_raddr;
  mm_ctl_t            feed_ctl;
  logic               out_load;
  logic               k_last, j_last;
  mm_ctl_t            ctl_w [MAX_DIM+1];
  logic signed [ELEM_BITS-1:0] a_w [MAX_DIM+1];
  logic [IDX_W-1:0]   k_w [MAX_DIM+1];
  logic signed [ACC_W-1:0] acc_w [MAX_DIM];
  logic               out_valid_q;

  assign k_last  = ((DIM_W'(k_q) + DIM_W'(1)) == inner_q);
  assign j_last  = ((DIM_W'(j_q) + DIM_W'(1)) == cols_b_q);
  assign a_waddr = ADDR_W'(in_row[IDX_W-1:0]) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col[IDX_W-1:0]);
  assign a_raddr = ADDR_W'(row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);

  always_comb begin
    state_d       = state_q;
    row_d         = row_q;
    k_d           = k_q;
    j_d           = j_q;
    s_axis_tready = 1'b0;
    a_we          = 1'b0;
    b_we          = 1'b0;
    feed_ctl      = '0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          case (s_axis_tuser)
            OP_LOAD_A: a_we = idx_ok;
            OP_LOAD_B: b_we = idx_ok;
            OP_COMPUTE: begin
              if ((FIELD_IDX_W + 1)'(in_row) < (FIELD_IDX_W + 1)'(rows_a_q)) begin
                row_d   = in_row[IDX_W-1:0];
                k_d     = '0;
                state_d = ST_FEED;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FEED: begin
        feed_ctl.vld   = 1'b1;
        feed_ctl.first = (k_q == '0);
        feed_ctl.last  = k_last;
        k_d            = k_q + IDX_W'(1);
        if (k_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // last cell's accumulator settles in the cycle after the final element leaves it
        if (ctl_w[MAX_DIM].vld && ctl_w[MAX_DIM].last) begin
          j_d     = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          j_d      = j_q + IDX_W'(1);
          if (j_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      k_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      k_q     <= k_d;
      j_q     <= j_d;
    end
  end

  // A store, registered read feeding the head of the chain
  logic signed [ELEM_BITS-1:0] a_mem [DEPTH];
  logic signed [ELEM_BITS-1:0] a_rd_q;
  logic [IDX_W-1:0]            feed_k_q;
  mm_ctl_t                     feed_ctl_q;

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_waddr] <= in_elem;
    end
  end

  always_ff @(posedge clk_i) begin
    a_rd_q   <= a_mem[a_raddr];
    feed_k_q <= k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feed_ctl_q <= '0;
    end else begin
      feed_ctl_q <= feed_ctl;
    end
  end

  assign ctl_w[0] = feed_ctl_q;
  assign a_w[0]   = a_rd_q;
  assign k_w[0]   = feed_k_q;

  // Chain of MAC cells, one per result column
  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    mm_mac_cell #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_BITS (ELEM_BITS),
      .CELL_IDX  (c)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_w[c]),
      .a_i     (a_w[c]),
      .k_i     (k_w[c]),
      .b_we_i  (b_we),
      .b_row_i (in_row[IDX_W-1:0]),
      .b_col_i (in_col[IDX_W-1:0]),
      .b_val_i (in_elem),
      .ctl_o   (ctl_w[c+1]),
      .a_o     (a_w[c+1]),
      .k_o     (k_w[c+1]),
      .acc_o   (acc_w[c])
    );
  end

  // Saturate the selected column to Q16.16
  logic signed [EXT_W-1:0] acc_ext;
  logic [SUM_W-1:0]        sum_sat;

  assign acc_ext = EXT_W'(acc_w[j_q]);

  always_comb begin
    if (acc_ext > SAT_MAX) begin
      sum_sat = SUM_W'(SAT_MAX);
    end else if (acc_ext < SAT_MIN) begin
      sum_sat = SUM_W'(SAT_MIN);
    end else begin
      sum_sat = SUM_W'(acc_ext);
    end
  end

  // Output register
  logic [IDX_W-1:0] out_row_q, out_col_q;
  logic [SUM_W-1:0] out_sum_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q  <= row_q;
      out_col_q  <= j_q;
      out_sum_q  <= sum_sat;
      out_last_q <= j_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_sum_q, FIELD_IDX_W'(out_col_q), FIELD_IDX_W'(out_row_q)};
  assign m_axis_tlast  = out_last_q;

endmodule
